// ===== rtl/swfh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swing foot Hermite interpolator package
// Fixed point formats, payload structs and register map of the core.
// ----------------------------------------------------------------------------
package swfh_pkg;

  localparam int FRAC_BITS = 16;

  localparam int T_W   = 24;
  localparam int P_W   = 24;
  localparam int V_W   = 32;
  localparam int CLR_W = 23;

  // Endpoint and difference widths leave room for the raised apex height.
  localparam int END_W  = P_W + 2;
  localparam int DIFF_W = P_W + 3;
  localparam int U_W    = FRAC_BITS + 1;
  localparam int PP_W   = U_W + 1 + DIFF_W;
  localparam int MAG_W  = PP_W + 1;

  localparam int LATENCY = U_W + V_W + 10;

  localparam logic [T_W-1:0]   T_MAX           = {T_W{1'b1}};
  localparam logic [U_W-1:0]   U_ONE           = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CLR_W-1:0] CLEARANCE_RESET = CLR_W'(6554);

  localparam int   ADDR_W        = 3;
  localparam logic REG_CLEARANCE = 1'b0;

  typedef logic signed [END_W-1:0]  end_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PP_W-1:0]   prod_t;

  typedef struct packed {
    logic        [T_W-1:0] query_time;
    logic signed [P_W-1:0] foot_x;
    logic signed [P_W-1:0] foot_y;
    logic signed [P_W-1:0] foot_z;
    logic        [T_W-1:0] touchdown_time;
    logic        [T_W-1:0] stance_duration;
    logic signed [P_W-1:0] next_x;
    logic signed [P_W-1:0] next_y;
    logic signed [P_W-1:0] next_z;
    logic        [T_W-1:0] next_touchdown_time;
  } query_t;

  typedef struct packed {
    logic signed [P_W-1:0] pos_x;
    logic signed [P_W-1:0] pos_y;
    logic signed [P_W-1:0] pos_z;
    logic signed [V_W-1:0] vel_x;
    logic signed [V_W-1:0] vel_y;
    logic signed [V_W-1:0] vel_z;
    logic                  in_contact;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/swing_foot_hermite_interpolator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swing foot Hermite interpolator core
// Samples foot position, velocity and contact between two footholds.
// ----------------------------------------------------------------------------
// Pipeline depth (LATENCY) is set by the 17 step blend weight divider and the
// 32 step velocity divider, one quotient bit per stage.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset clears the valid line and loads the default clearance.
module swing_foot_hermite_interpolator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  swfh_pkg::query_t              query,
  output logic                          busy,
  output logic                          done,
  output swfh_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swfh_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import swfh_pkg::*;

  localparam prod_t POS_HI = prod_t'(2**(P_W-1) - 1);
  localparam prod_t POS_LO = prod_t'(-(2**(P_W-1)));
  localparam logic [V_W-1:0] VEL_HI = {1'b0, {(V_W-1){1'b1}}};
  localparam logic [V_W-1:0] VEL_LO = {1'b1, {(V_W-1){1'b0}}};

  typedef struct packed {
    logic           contact;
    logic [T_W-1:0] tf;
    end_t           xa;
    end_t           xb;
    end_t           ya;
    end_t           yb;
    end_t           za;
    end_t           zb;
  } carry_t;

  typedef struct packed {
    logic           contact;
    logic [T_W-1:0] tf;
    logic [T_W-1:0] ts;
    end_t           xa;
    end_t           xb;
    end_t           ya;
    end_t           yb;
    end_t           z0;
    end_t           z1;
    end_t           zm;
  } s2_t;

  typedef struct packed {
    carry_t         c;
    logic [T_W-1:0] n_xy;
    logic [T_W-1:0] n_z;
  } s3_t;

  typedef struct packed {
    carry_t         c;
    logic [T_W-1:0] r_xy;
    logic [T_W-1:0] r_z;
    logic [U_W-1:0] q_xy;
    logic [U_W-1:0] q_z;
  } ud_t;

  typedef struct packed {
    carry_t         c;
    logic [U_W-1:0] u_xy;
    logic [U_W-1:0] u_z;
    logic [U_W-1:0] u2_xy;
    logic [U_W-1:0] u2_z;
  } w1_t;

  typedef struct packed {
    carry_t         c;
    logic [U_W-1:0] u_xy;
    logic [U_W-1:0] u_z;
    logic [U_W-1:0] u2_xy;
    logic [U_W-1:0] u2_z;
    logic [U_W-1:0] u3_xy;
    logic [U_W-1:0] u3_z;
  } w2_t;

  typedef struct packed {
    carry_t         c;
    logic [U_W-1:0] w_xy;
    logic [U_W-1:0] s_xy;
    logic [U_W-1:0] w_z;
    logic [U_W-1:0] s_z;
    diff_t          dx;
    diff_t          dy;
    diff_t          dz;
  } w3_t;

  typedef struct packed {
    carry_t c;
    prod_t  pp_x;
    prod_t  pp_y;
    prod_t  pp_z;
    prod_t  vp_x;
    prod_t  vp_y;
    prod_t  vp_z;
  } m_t;

  typedef struct packed {
    logic                  contact;
    logic [T_W-1:0]        tf;
    logic signed [P_W-1:0] pos_x;
    logic signed [P_W-1:0] pos_y;
    logic signed [P_W-1:0] pos_z;
    logic [MAG_W-1:0]      mag_x;
    logic [MAG_W-1:0]      mag_y;
    logic [MAG_W-1:0]      mag_z;
    logic                  neg_x;
    logic                  neg_y;
    logic                  neg_z;
  } p_t;

  typedef struct packed {
    logic [T_W-1:0] r;
    logic [V_W-1:0] q;
    logic [V_W-1:0] lo;
    logic           ovf;
    logic           neg;
  } vlane_t;

  typedef struct packed {
    logic                  contact;
    logic [T_W-1:0]        tf;
    logic signed [P_W-1:0] pos_x;
    logic signed [P_W-1:0] pos_y;
    logic signed [P_W-1:0] pos_z;
    vlane_t                lx;
    vlane_t                ly;
    vlane_t                lz;
  } vd_t;

  // One restoring division step: returns the quotient bit above the remainder.
  function automatic logic [T_W:0] div_step(input logic [T_W-1:0] r, input logic bit_in,
                                            input logic [T_W-1:0] d);
    logic [T_W:0] r2;
    logic [T_W:0] sub;
    logic         ge;
    r2  = {r, bit_in};
    sub = r2 - {1'b0, d};
    ge  = (r2 >= {1'b0, d});
    return {ge, ge ? sub[T_W-1:0] : r2[T_W-1:0]};
  endfunction

  function automatic ud_t ud_init(input s3_t s);
    ud_t          o;
    logic [T_W:0] a;
    logic [T_W:0] b;
    a      = div_step({1'b0, s.n_xy[T_W-1:1]}, s.n_xy[0], s.c.tf);
    b      = div_step({1'b0, s.n_z[T_W-1:1]}, s.n_z[0], s.c.tf);
    o.c    = s.c;
    o.r_xy = a[T_W-1:0];
    o.r_z  = b[T_W-1:0];
    o.q_xy = {{(U_W-1){1'b0}}, a[T_W]};
    o.q_z  = {{(U_W-1){1'b0}}, b[T_W]};
    return o;
  endfunction

  function automatic ud_t ud_step(input ud_t s);
    ud_t          o;
    logic [T_W:0] a;
    logic [T_W:0] b;
    a      = div_step(s.r_xy, 1'b0, s.c.tf);
    b      = div_step(s.r_z, 1'b0, s.c.tf);
    o      = s;
    o.r_xy = a[T_W-1:0];
    o.r_z  = b[T_W-1:0];
    o.q_xy = {s.q_xy[U_W-2:0], a[T_W]};
    o.q_z  = {s.q_z[U_W-2:0], b[T_W]};
    return o;
  endfunction

  function automatic logic [U_W-1:0] pos_weight(input logic [U_W-1:0] u2,
                                                input logic [U_W-1:0] u3);
    logic signed [U_W+2:0] acc;
    acc = $signed({3'b000, u2}) + $signed({2'b00, u2, 1'b0}) - $signed({2'b00, u3, 1'b0});
    if (acc < 0) begin
      return '0;
    end else if (acc > $signed({3'b000, U_ONE})) begin
      return U_ONE;
    end else begin
      return acc[U_W-1:0];
    end
  endfunction

  // The slope weight never reaches 2^(FRAC_BITS+1), so it fits the weight width.
  function automatic logic [U_W-1:0] slope_weight(input logic [U_W-1:0] u,
                                                  input logic [U_W-1:0] u2);
    logic [U_W-1:0] d;
    logic [U_W+1:0] t6;
    d  = u - u2;
    t6 = {d, 2'b00} + {1'b0, d, 1'b0};
    return t6[U_W-1:0];
  endfunction

  function automatic logic signed [P_W-1:0] sat_pos(input prod_t v);
    if (v > POS_HI) begin
      return POS_HI[P_W-1:0];
    end else if (v < POS_LO) begin
      return POS_LO[P_W-1:0];
    end else begin
      return v[P_W-1:0];
    end
  endfunction

  function automatic vlane_t vinit(input logic [MAG_W-1:0] mag, input logic neg,
                                   input logic [T_W-1:0] d);
    vlane_t o;
    o.r   = T_W'(mag[MAG_W-1:V_W]);
    o.q   = '0;
    o.lo  = mag[V_W-1:0];
    o.ovf = (T_W'(mag[MAG_W-1:V_W]) >= d);
    o.neg = neg;
    return o;
  endfunction

  function automatic vlane_t vstep(input vlane_t l, input logic [T_W-1:0] d);
    vlane_t       o;
    logic [T_W:0] s;
    s    = div_step(l.r, l.lo[V_W-1], d);
    o    = l;
    o.r  = s[T_W-1:0];
    o.q  = {l.q[V_W-2:0], s[T_W]};
    o.lo = {l.lo[V_W-2:0], 1'b0};
    return o;
  endfunction

  function automatic vd_t vd_step(input vd_t s);
    vd_t o;
    o    = s;
    o.lx = vstep(s.lx, s.tf);
    o.ly = vstep(s.ly, s.tf);
    o.lz = vstep(s.lz, s.tf);
    return o;
  endfunction

  function automatic logic signed [V_W-1:0] vsat(input vlane_t l);
    if (l.neg) begin
      if (l.ovf || (l.q[V_W-1] && (l.q[V_W-2:0] != '0))) begin
        return VEL_LO;
      end else begin
        return -l.q;
      end
    end else if (l.ovf || l.q[V_W-1]) begin
      return VEL_HI;
    end else begin
      return l.q;
    end
  endfunction

  // Configuration register
  logic [CLR_W-1:0] clearance;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearance <= CLEARANCE_RESET;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CLEARANCE)) begin
      clearance <= pwdata[CLR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_CLEARANCE) ? 32'(clearance) : 32'd0;
  assign busy   = 1'b0;

  // Valid line, one bit per pipeline register
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start};
    end
  end

  assign done = vld[LATENCY-1];

  // Stage 1: capture the request and the saturated liftoff time
  query_t         s1_q;
  logic [T_W-1:0] s1_lift;
  logic           s1_forever;
  logic [T_W:0]   lift_sum;

  assign lift_sum = {1'b0, query.touchdown_time} + {1'b0, query.stance_duration};

  always_ff @(posedge clk) begin
    s1_q       <= query;
    s1_lift    <= lift_sum[T_W] ? T_MAX : lift_sum[T_W-1:0];
    s1_forever <= (query.stance_duration == T_MAX);
  end

  // Stage 2: phase decision; outside swing both endpoints are the resting foothold
  logic hold_cur;
  logic hold_next;
  logic swing;
  end_t x0e, y0e, z0e, x1e, y1e, z1e, zmax, zmid;

  assign hold_cur  = s1_forever || (s1_q.query_time < s1_lift);
  assign hold_next = !hold_cur && ((s1_q.query_time > s1_q.next_touchdown_time) ||
                                   (s1_q.next_touchdown_time == s1_lift));
  assign swing     = !hold_cur && !hold_next;
  assign x0e       = END_W'(s1_q.foot_x);
  assign y0e       = END_W'(s1_q.foot_y);
  assign z0e       = END_W'(s1_q.foot_z);
  assign x1e       = END_W'(s1_q.next_x);
  assign y1e       = END_W'(s1_q.next_y);
  assign z1e       = END_W'(s1_q.next_z);
  assign zmax      = (s1_q.foot_z > s1_q.next_z) ? z0e : z1e;
  assign zmid      = END_W'($signed({1'b0, clearance})) + zmax;

  s2_t s2;

  always_ff @(posedge clk) begin
    s2.contact <= !swing;
    s2.tf      <= swing ? (s1_q.next_touchdown_time - s1_lift) : T_W'(1);
    s2.ts      <= swing ? (s1_q.query_time - s1_lift) : '0;
    s2.xa      <= (hold_cur || swing) ? x0e : x1e;
    s2.xb      <= hold_cur ? x0e : x1e;
    s2.ya      <= (hold_cur || swing) ? y0e : y1e;
    s2.yb      <= hold_cur ? y0e : y1e;
    s2.z0      <= (hold_cur || swing) ? z0e : z1e;
    s2.z1      <= hold_cur ? z0e : z1e;
    s2.zm      <= swing ? zmid : (hold_cur ? z0e : z1e);
  end

  // Stage 3: pick the z half segment and its numerator
  logic [T_W:0]   twots;
  logic [T_W:0]   twots_sub;
  logic           zsel;
  s3_t            s3;

  assign twots     = {s2.ts, 1'b0};
  assign twots_sub = twots - {1'b0, s2.tf};
  assign zsel      = (twots < {1'b0, s2.tf});

  always_ff @(posedge clk) begin
    s3.c.contact <= s2.contact;
    s3.c.tf      <= s2.tf;
    s3.c.xa      <= s2.xa;
    s3.c.xb      <= s2.xb;
    s3.c.ya      <= s2.ya;
    s3.c.yb      <= s2.yb;
    s3.c.za      <= zsel ? s2.z0 : s2.zm;
    s3.c.zb      <= zsel ? s2.zm : s2.z1;
    s3.n_xy      <= s2.ts;
    s3.n_z       <= zsel ? twots[T_W-1:0] : twots_sub[T_W-1:0];
  end

  // Blend weight dividers, one quotient bit per stage
  ud_t ud [U_W];

  always_ff @(posedge clk) begin
    ud[0] <= ud_init(s3);
    for (int k = 1; k < U_W; k++) begin
      ud[k] <= ud_step(ud[k-1]);
    end
  end

  // Powers of the blend parameter
  logic [2*U_W-1:0] sq_xy, sq_z, cu_xy, cu_z;
  w1_t w1;
  w2_t w2;

  assign sq_xy = ud[U_W-1].q_xy * ud[U_W-1].q_xy;
  assign sq_z  = ud[U_W-1].q_z * ud[U_W-1].q_z;

  always_ff @(posedge clk) begin
    w1.c     <= ud[U_W-1].c;
    w1.u_xy  <= ud[U_W-1].q_xy;
    w1.u_z   <= ud[U_W-1].q_z;
    w1.u2_xy <= sq_xy[FRAC_BITS+U_W-1:FRAC_BITS];
    w1.u2_z  <= sq_z[FRAC_BITS+U_W-1:FRAC_BITS];
  end

  assign cu_xy = w1.u2_xy * w1.u_xy;
  assign cu_z  = w1.u2_z * w1.u_z;

  always_ff @(posedge clk) begin
    w2.c     <= w1.c;
    w2.u_xy  <= w1.u_xy;
    w2.u_z   <= w1.u_z;
    w2.u2_xy <= w1.u2_xy;
    w2.u2_z  <= w1.u2_z;
    w2.u3_xy <= cu_xy[FRAC_BITS+U_W-1:FRAC_BITS];
    w2.u3_z  <= cu_z[FRAC_BITS+U_W-1:FRAC_BITS];
  end

  // Hermite weights and endpoint differences
  w3_t w3;

  always_ff @(posedge clk) begin
    w3.c    <= w2.c;
    w3.w_xy <= pos_weight(w2.u2_xy, w2.u3_xy);
    w3.s_xy <= slope_weight(w2.u_xy, w2.u2_xy);
    w3.w_z  <= pos_weight(w2.u2_z, w2.u3_z);
    w3.s_z  <= slope_weight(w2.u_z, w2.u2_z);
    w3.dx   <= DIFF_W'(w2.c.xb) - DIFF_W'(w2.c.xa);
    w3.dy   <= DIFF_W'(w2.c.yb) - DIFF_W'(w2.c.ya);
    w3.dz   <= DIFF_W'(w2.c.zb) - DIFF_W'(w2.c.za);
  end

  // Weight times difference
  prod_t pp_x, pp_y, pp_z, vp_x, vp_y, vp_z;
  m_t    m;

  assign pp_x = $signed({1'b0, w3.w_xy}) * w3.dx;
  assign pp_y = $signed({1'b0, w3.w_xy}) * w3.dy;
  assign pp_z = $signed({1'b0, w3.w_z}) * w3.dz;
  assign vp_x = $signed({1'b0, w3.s_xy}) * w3.dx;
  assign vp_y = $signed({1'b0, w3.s_xy}) * w3.dy;
  assign vp_z = $signed({1'b0, w3.s_z}) * w3.dz;

  always_ff @(posedge clk) begin
    m.c    <= w3.c;
    m.pp_x <= pp_x;
    m.pp_y <= pp_y;
    m.pp_z <= pp_z;
    m.vp_x <= vp_x;
    m.vp_y <= vp_y;
    m.vp_z <= vp_z;
  end

  // Positions, and sign and magnitude of the velocity numerators.
  // The z segments span half the flight, which doubles their slope.
  logic signed [MAG_W-1:0] vs_x, vs_y, vs_z;
  p_t p;

  assign vs_x = MAG_W'(m.vp_x);
  assign vs_y = MAG_W'(m.vp_y);
  assign vs_z = $signed({m.vp_z, 1'b0});

  always_ff @(posedge clk) begin
    p.contact <= m.c.contact;
    p.tf      <= m.c.tf;
    p.pos_x   <= sat_pos(PP_W'(m.c.xa) + (m.pp_x >>> FRAC_BITS));
    p.pos_y   <= sat_pos(PP_W'(m.c.ya) + (m.pp_y >>> FRAC_BITS));
    p.pos_z   <= sat_pos(PP_W'(m.c.za) + (m.pp_z >>> FRAC_BITS));
    p.neg_x   <= vs_x[MAG_W-1];
    p.neg_y   <= vs_y[MAG_W-1];
    p.neg_z   <= vs_z[MAG_W-1];
    p.mag_x   <= vs_x[MAG_W-1] ? MAG_W'(-vs_x) : MAG_W'(vs_x);
    p.mag_y   <= vs_y[MAG_W-1] ? MAG_W'(-vs_y) : MAG_W'(vs_y);
    p.mag_z   <= vs_z[MAG_W-1] ? MAG_W'(-vs_z) : MAG_W'(vs_z);
  end

  // Velocity dividers. The first stage flags a quotient that cannot fit 32 bits.
  vd_t vd [V_W+1];

  always_ff @(posedge clk) begin
    vd[0].contact <= p.contact;
    vd[0].tf      <= p.tf;
    vd[0].pos_x   <= p.pos_x;
    vd[0].pos_y   <= p.pos_y;
    vd[0].pos_z   <= p.pos_z;
    vd[0].lx      <= vinit(p.mag_x, p.neg_x, p.tf);
    vd[0].ly      <= vinit(p.mag_y, p.neg_y, p.tf);
    vd[0].lz      <= vinit(p.mag_z, p.neg_z, p.tf);
    for (int k = 1; k <= V_W; k++) begin
      vd[k] <= vd_step(vd[k-1]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    result.pos_x      <= vd[V_W].pos_x;
    result.pos_y      <= vd[V_W].pos_y;
    result.pos_z      <= vd[V_W].pos_z;
    result.vel_x      <= vsat(vd[V_W].lx);
    result.vel_y      <= vsat(vd[V_W].ly);
    result.vel_z      <= vsat(vd[V_W].lz);
    result.in_contact <= vd[V_W].contact;
  end

`ifndef SYNTHESIS
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result strobe without a matching request");

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("request did not produce a result");

  a_contact_still: assert property (@(posedge clk) disable iff (rst)
    (done && result.in_contact) |->
      (result.vel_x == '0) && (result.vel_y == '0) && (result.vel_z == '0))
    else $error("foot in contact with nonzero velocity");

  a_swing_flight_time: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && !s2.contact) |-> (s2.tf != '0) && (s2.ts <= s2.tf))
    else $error("swing with empty flight time or time outside flight");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_swing_foot_hermite_interpolator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the swing foot Hermite interpolator core
// Directed and random trajectory requests are sent in bursts under several
// clearance settings. Each result is checked field by field against a
// fixed point prediction of the swing trajectory.
// ----------------------------------------------------------------------------
module tb_swing_foot_hermite_interpolator_core;
  import swfh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  query_t query = '0;
  logic busy, done, pready;
  result_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  swing_foot_hermite_interpolator_core dut (
    .clk(clk), .rst(rst), .start(start), .query(query), .busy(busy),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  query_t  pending_queries[$];
  result_t expected_results[$];
  longint  clearance_model = 6554;
  int      error_count = 0;
  int      burst_left = 4;
  int      gap_left = 0;
  int      quiet_cycles = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // One Hermite segment from a to b at blend parameter u.
  function automatic void hermite_segment(longint a, longint b, longint u, longint tf,
                                          longint scale, output longint p, output longint v);
    longint u2, u3, w, s;
    u2 = (u * u) >> FRAC_BITS;
    u3 = (u2 * u) >> FRAC_BITS;
    w = clamp(3 * u2 - 2 * u3, 0, longint'(1) << FRAC_BITS);
    s = 6 * (u - u2);
    p = a + ((w * (b - a)) >>> FRAC_BITS);
    v = clamp((scale * s * (b - a)) / tf, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic result_t foot_trajectory(query_t q);
    result_t r;
    longint t, td, st, ntd, lift, tf, ts, u, zmid;
    longint x0, y0, z0, x1, y1, z1, px, py, pz, vx, vy, vz;
    t = q.query_time; td = q.touchdown_time; st = q.stance_duration;
    ntd = q.next_touchdown_time;
    x0 = $signed(q.foot_x); y0 = $signed(q.foot_y); z0 = $signed(q.foot_z);
    x1 = $signed(q.next_x); y1 = $signed(q.next_y); z1 = $signed(q.next_z);
    vx = 0; vy = 0; vz = 0;
    r.in_contact = 1'b1;
    lift = td + st;
    if (lift > longint'(T_MAX)) lift = T_MAX;
    if (st == longint'(T_MAX) || t < lift) begin
      px = x0; py = y0; pz = z0;
    end else if (t > ntd || ntd == lift) begin
      px = x1; py = y1; pz = z1;
    end else begin
      tf = ntd - lift;
      ts = t - lift;
      zmid = clearance_model + (z0 > z1 ? z0 : z1);
      u = (ts << FRAC_BITS) / tf;
      hermite_segment(x0, x1, u, tf, 1, px, vx);
      hermite_segment(y0, y1, u, tf, 1, py, vy);
      if (2 * ts < tf) begin
        u = ((2 * ts) << FRAC_BITS) / tf;
        hermite_segment(z0, zmid, u, tf, 2, pz, vz);
      end else begin
        u = ((2 * ts - tf) << FRAC_BITS) / tf;
        hermite_segment(zmid, z1, u, tf, 2, pz, vz);
      end
      r.in_contact = 1'b0;
    end
    r.pos_x = P_W'(clamp(px, -8388608, 8388607));
    r.pos_y = P_W'(clamp(py, -8388608, 8388607));
    r.pos_z = P_W'(clamp(pz, -8388608, 8388607));
    r.vel_x = V_W'(vx);
    r.vel_y = V_W'(vy);
    r.vel_z = V_W'(vz);
    return r;
  endfunction

  function automatic logic [P_W-1:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return P_W'($urandom);
      1: return 24'h7FFFFF - P_W'($urandom_range(0, 3));
      2: return 24'h800000 + P_W'($urandom_range(0, 3));
      default: return P_W'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Mostly well-formed swings with random content, the rest stance, landed or noise.
  function automatic query_t random_query();
    query_t q;
    longint lift, tf;
    int mode;
    q = query_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom});
    mode = $urandom_range(0, 9);
    if (mode == 0) return q;
    q.foot_x = rand_pos(); q.foot_y = rand_pos(); q.foot_z = rand_pos();
    q.next_x = rand_pos(); q.next_y = rand_pos(); q.next_z = rand_pos();
    q.touchdown_time = T_W'($urandom_range(0, 24'hFFFFFF));
    q.stance_duration = T_W'($urandom_range(0, 24'h0FFFFF));
    lift = longint'(q.touchdown_time) + q.stance_duration;
    case ($urandom_range(0, 3))
      0: tf = $urandom_range(1, 8);
      1: tf = $urandom_range(1, 24'hFFFFFF);
      default: tf = $urandom_range(1, 24'h03FFFF);
    endcase
    if (lift + tf > longint'(T_MAX)) begin
      q.touchdown_time = T_W'($urandom_range(0, 24'h0FFFFF));
      lift = longint'(q.touchdown_time) + q.stance_duration;
      tf = clamp(tf, 1, longint'(T_MAX) - lift);
    end
    q.next_touchdown_time = T_W'(lift + tf);
    if (mode == 1)
      q.query_time = (lift > 0) ? T_W'($urandom_range(0, lift - 1)) : '0;
    else if (mode == 2 && q.next_touchdown_time != T_MAX)
      q.query_time = T_W'($urandom_range(lift + tf + 1, T_MAX));
    else
      q.query_time = T_W'(lift + $urandom_range(0, tf));
    return q;
  endfunction

  function automatic query_t swing_query(longint td, longint st, longint tf, longint ts,
                                         longint a, longint b, longint za, longint zb);
    query_t q;
    q.touchdown_time = T_W'(td);
    q.stance_duration = T_W'(st);
    q.next_touchdown_time = T_W'(td + st + tf);
    q.query_time = T_W'(td + st + ts);
    q.foot_x = P_W'(a); q.foot_y = P_W'(b); q.foot_z = P_W'(za);
    q.next_x = P_W'(b); q.next_y = P_W'(a); q.next_z = P_W'(zb);
    return q;
  endfunction

  // Appends a request to the tail of the pending queue.
  task automatic queue_request(query_t q);
    pending_queries = {pending_queries, q};
  endtask

  task automatic add_directed();
    query_t q;
    // Stance forever keeps the foot on the current foothold at any time.
    q = swing_query(0, 0, 0, 0, 100, -100, 5, 7);
    q.stance_duration = T_MAX; q.query_time = T_MAX; q.next_touchdown_time = 24'h10;
    queue_request(q);
    // Liftoff sum overflows and saturates.
    q = swing_query(0, 0, 0, 0, 1, 2, 3, 4);
    q.touchdown_time = 24'hF00000; q.stance_duration = 24'h200000;
    q.query_time = T_MAX; q.next_touchdown_time = T_MAX;
    queue_request(q);
    q.query_time = 24'hFFFFFE;
    queue_request(q);
    // Before liftoff, after touchdown, and a next touchdown ahead of liftoff.
    queue_request(swing_query(1000, 500, 2000, -1, 10, 20, 30, 40));
    queue_request(swing_query(1000, 500, 2000, 2001, 10, 20, 30, 40));
    q = swing_query(5000, 500, 0, 10, 10, 20, 30, 40);
    q.next_touchdown_time = 100;
    queue_request(q);
    // Zero flight time.
    queue_request(swing_query(300, 300, 0, 0, 8388607, -8388608, 0, 0));
    // Start, middle and end of a swing, and its two quarter points.
    queue_request(swing_query(0, 0, 65536, 0, -8388608, 8388607, -8388608, 8388607));
    queue_request(swing_query(0, 0, 65536, 32768, -8388608, 8388607, -8388608, 8388607));
    queue_request(swing_query(0, 0, 65536, 65536, -8388608, 8388607, -8388608, 8388607));
    queue_request(swing_query(0, 0, 65536, 16384, 65536, -65536, 0, 65536));
    queue_request(swing_query(0, 0, 65536, 49152, 65536, -65536, 65536, 0));
    // Flights of one and three ticks drive velocities toward saturation.
    queue_request(swing_query(0, 0, 1, 0, -8388608, 8388607, 8388607, -8388608));
    queue_request(swing_query(0, 0, 3, 1, 8388607, -8388608, -8388608, 8388607));
    queue_request(swing_query(0, 0, 3, 2, 8388607, -8388608, 8388607, 8388607));
    // Longest flight with the widest times.
    queue_request(swing_query(0, 0, 24'hFFFFFF, 24'h7FFFFF, 8388607, -8388608, 8388607,
                              8388607));
    queue_request(swing_query(24'hFFFFFE, 0, 1, 1, 1, 2, 3, 4));
  endtask

  task automatic write_clearance(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({REG_CLEARANCE, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    clearance_model = value & 32'h7FFFFF;
  endtask

  task automatic wait_idle();
    while (pending_queries.size() != 0 || expected_results.size() != 0 || start)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results = {expected_results, foot_trajectory(query)};
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_queries.size() != 0) begin
        query <= pending_queries.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.pos_x !== exp_r.pos_x)
          $display("%0t: pos_x expected %h actual %h", $time, exp_r.pos_x, result.pos_x);
        if (result.pos_y !== exp_r.pos_y)
          $display("%0t: pos_y expected %h actual %h", $time, exp_r.pos_y, result.pos_y);
        if (result.pos_z !== exp_r.pos_z)
          $display("%0t: pos_z expected %h actual %h", $time, exp_r.pos_z, result.pos_z);
        if (result.vel_x !== exp_r.vel_x)
          $display("%0t: vel_x expected %h actual %h", $time, exp_r.vel_x, result.vel_x);
        if (result.vel_y !== exp_r.vel_y)
          $display("%0t: vel_y expected %h actual %h", $time, exp_r.vel_y, result.vel_y);
        if (result.vel_z !== exp_r.vel_z)
          $display("%0t: vel_z expected %h actual %h", $time, exp_r.vel_z, result.vel_z);
        if (result.in_contact !== exp_r.in_contact)
          $display("%0t: in_contact expected %b actual %b", $time, exp_r.in_contact,
                   result.in_contact);
        if (result !== exp_r) error_count++;
      end
    end
  end

  // Watchdog on cycles with work outstanding but no request or result moving.
  always @(posedge clk) begin
    if ((start && !busy) || done || (pending_queries.size() == 0 &&
        expected_results.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [31:0] settings[5];
    settings[0] = 32'd6554;
    settings[1] = 32'd0;
    settings[2] = 32'h007FFFFF;
    settings[3] = $urandom;
    settings[4] = 32'd6554;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase != 0) write_clearance(settings[phase]);
      for (int n = 0; n < 350; n++) queue_request(random_query());
      wait_idle();
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== swing_foot_hermite_interpolator_core.f =====
rtl/swfh_pkg.sv
rtl/swing_foot_hermite_interpolator_core.sv
dv/tb_swing_foot_hermite_interpolator_core.sv
